/* hw/rtl/hfmi_pkg.sv */
// hfmi_pkg: types, codes and constants shared by the first-match index block
// no dependencies
`default_nettype none

package hfmi_pkg;

   // default sizes of the key store and the slot store
   localparam int DEF_MAX_ENTRIES = 4096;
   localparam int DEF_SLOTS       = 8192;

   localparam int KEY_W   = 32;
   localparam int CMD_W   = 2;
   localparam int HB_W    = 4;
   localparam int DSLOT_W = 14;
   localparam int CSR_IDX_W = 2;

   localparam logic [KEY_W-1:0] MISSING_KEY = 32'h8000_0000;
   localparam logic [KEY_W-1:0] HASH_MULT   = 32'd3141592653;
   localparam logic [HB_W-1:0]  MIN_HASH_BITS = 4'd8;
   localparam int               MAX_HASH_BITS = 13;
   localparam int               MIN_DIRECT_SLOTS = 3;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECT    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NOMATCH   = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]        cmd;
      logic signed [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] match_value;
      logic                    found;
      logic                    overflow;
   } rsp_type;

   typedef struct packed {
      logic                    mode;
      logic [HB_W-1:0]         hash_bits;
      logic [DSLOT_W-1:0]      direct_slots;
      logic signed [KEY_W-1:0] nomatch_value;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      mode:          1'b0,
      hash_bits:     4'd8,
      direct_slots:  14'd3,
      nomatch_value: 32'sh8000_0000
   };

endpackage

`default_nettype wire

/* hw/rtl/hfmi_ram.sv */
// hfmi_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
`default_nettype none

module hfmi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* hw/rtl/hfmi_slot_addr.sv */
// hfmi_slot_addr: home slot of a key (registered multiplicative hash or direct index)
// depends on hfmi_pkg
`default_nettype none

module hfmi_slot_addr #(
   parameter int SLOTS = hfmi_pkg::DEF_SLOTS
) (
   input  wire logic                     clock,
   input  wire logic [31:0]              key,
   input  wire hfmi_pkg::cfg_type        cfg,
   output logic      [$clog2(SLOTS)-1:0] home_slot,
   output logic                          home_ok,
   output logic      [$clog2(SLOTS)-1:0] slot_mask
);

   localparam int AW   = $clog2(SLOTS);
   localparam int SW   = $clog2(SLOTS + 1);
   localparam int CW   = (hfmi_pkg::DSLOT_W > SW) ? hfmi_pkg::DSLOT_W : SW;
   localparam int FLOG = SW - 1;
   localparam int MAX_HB = (FLOG < hfmi_pkg::MAX_HASH_BITS) ? FLOG
                                                           : hfmi_pkg::MAX_HASH_BITS;

   logic [31:0]   prod_ff;
   logic [31:0]   prod_in;
   logic [3:0]    hb;
   logic [31:0]   shifted;
   logic [CW-1:0] ds_ext;
   logic [CW-1:0] d_eff;
   logic [CW-1:0] d_last;
   logic          missing;
   logic          direct_ok;
   logic [AW-1:0] direct_slot;

   assign prod_in = key * hfmi_pkg::HASH_MULT;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_comb begin
      if (cfg.hash_bits < hfmi_pkg::MIN_HASH_BITS) begin
         hb = hfmi_pkg::MIN_HASH_BITS;
      end else if (cfg.hash_bits > 4'(MAX_HB)) begin
         hb = 4'(MAX_HB);
      end else begin
         hb = cfg.hash_bits;
      end
   end

   // top hb bits of the product
   assign shifted   = prod_ff >> (6'd32 - {2'b00, hb});
   assign slot_mask = AW'((32'd1 << hb) - 32'd1);

   assign ds_ext = CW'(cfg.direct_slots);

   always_comb begin
      if (ds_ext < CW'(hfmi_pkg::MIN_DIRECT_SLOTS)) begin
         d_eff = CW'(hfmi_pkg::MIN_DIRECT_SLOTS);
      end else if (ds_ext > CW'(SLOTS)) begin
         d_eff = CW'(SLOTS);
      end else begin
         d_eff = ds_ext;
      end
   end

   // missing key lives in the last direct slot
   assign d_last      = d_eff - CW'(1);
   assign missing     = (key == hfmi_pkg::MISSING_KEY);
   assign direct_ok   = missing || (!key[31] && (key < 32'(d_last)));
   assign direct_slot = missing ? d_last[AW-1:0] : key[AW-1:0];

   assign home_slot = cfg.mode ? direct_slot : shifted[AW-1:0];
   assign home_ok   = cfg.mode ? direct_ok : 1'b1;

endmodule

`default_nettype wire

/* hw/rtl/hash_first_match_index.sv */
// hash_first_match_index: first-position key matcher, probe sequencer and stores
// depends on hfmi_pkg, hfmi_ram, hfmi_slot_addr
`default_nettype none

// Insert, lookup and clear commands are taken while busy is low. A lookup or
// a stored insert holds busy through hash, home, read and check when its home
// slot is empty or the block is in direct mode with the key in range, and
// through hash and home only when a direct mode key is out of range. In
// hashed mode each occupied slot with another key that it walks past adds
// key, read and check states, and a key state when it stops on a matching
// key or on the last slot in use without finding a hole. The single slot
// store read port, followed by a key store read, sets the cost of each probe.
// An insert dropped for lack of room and the unused command do not raise
// busy. A clear, and the period after reset, hold busy while the slot store
// is zeroed one entry per cycle. Each lookup gives one result as busy drops,
// on rsp_payload for the single cycle rsp_valid is high; the receiver cannot
// stall it. csr_ready stays high; the user must write registers through csr_*
// only while busy is low and no result is still due, which is not enforced.
module hash_first_match_index #(
   parameter int MAX_ENTRIES = hfmi_pkg::DEF_MAX_ENTRIES,
   parameter int SLOTS       = hfmi_pkg::DEF_SLOTS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire hfmi_pkg::req_type                  req_payload,
   output logic                                    rsp_valid,
   output hfmi_pkg::rsp_type                       rsp_payload,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [hfmi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [31:0]                        csr_wdata
);

   localparam int AW  = $clog2(SLOTS);
   localparam int PW  = $clog2(MAX_ENTRIES + 1);
   localparam int KAW = $clog2(MAX_ENTRIES);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_HASH  = 3'd2;
   localparam logic [2:0] ST_HOME  = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_CHECK = 3'd5;
   localparam logic [2:0] ST_KEY   = 3'd6;

   logic [2:0]                    state_ff, state_in;
   hfmi_pkg::cfg_type             cfg_ff, cfg_in;
   logic [hfmi_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic [31:0]                   key_ff, key_in;
   logic [PW-1:0]                 count_ff, count_in;
   logic [PW-1:0]                 pos_ff, pos_in;
   logic                          overflow_ff, overflow_in;
   logic [AW-1:0]                 slot_idx_ff, slot_idx_in;
   logic [AW-1:0]                 probe_ff, probe_in;
   logic [AW-1:0]                 clr_ff, clr_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   hfmi_pkg::rsp_type             rsp_ff, rsp_in;

   logic          slot_we;
   logic [AW-1:0] slot_wa;
   logic [PW-1:0] slot_wd;
   logic [PW-1:0] slot_rdata;
   logic [PW-1:0] slot_prev;
   logic          key_we;
   logic [31:0]   key_rdata;
   logic [AW-1:0] home_slot;
   logic          home_ok;
   logic [AW-1:0] slot_mask;

   function automatic hfmi_pkg::rsp_type make_rsp(logic [PW-1:0] pos,
                                                  logic signed [31:0] nomatch,
                                                  logic ovf);
      hfmi_pkg::rsp_type r;
      r.found       = (pos != '0);
      r.match_value = r.found ? signed'(32'(pos)) : nomatch;
      r.overflow    = ovf;
      return r;
   endfunction

   hfmi_slot_addr #(
      .SLOTS(SLOTS)
   ) u_slot_addr (
      .clock     (clock),
      .key       (key_ff),
      .cfg       (cfg_ff),
      .home_slot (home_slot),
      .home_ok   (home_ok),
      .slot_mask (slot_mask)
   );

   hfmi_ram #(
      .WIDTH(PW),
      .DEPTH(SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_wa),
      .wr_data (slot_wd),
      .rd_addr (slot_idx_ff),
      .rd_data (slot_rdata)
   );

   // slot entries hold 1-based positions
   assign slot_prev = slot_rdata - PW'(1);

   hfmi_ram #(
      .WIDTH(32),
      .DEPTH(MAX_ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (count_ff[KAW-1:0]),
      .wr_data (req_payload.key),
      .rd_addr (slot_prev[KAW-1:0]),
      .rd_data (key_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      cfg_in       = cfg_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      overflow_in  = overflow_ff;
      slot_idx_in  = slot_idx_ff;
      probe_in     = probe_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      slot_we      = 1'b0;
      slot_wa      = slot_idx_ff;
      slot_wd      = pos_ff;
      key_we       = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            hfmi_pkg::CSR_MODE:      cfg_in.mode          = csr_wdata[0];
            hfmi_pkg::CSR_HASH_BITS: cfg_in.hash_bits     = csr_wdata[hfmi_pkg::HB_W-1:0];
            hfmi_pkg::CSR_DIRECT:    cfg_in.direct_slots  = csr_wdata[hfmi_pkg::DSLOT_W-1:0];
            hfmi_pkg::CSR_NOMATCH:   cfg_in.nomatch_value = signed'(csr_wdata);
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in = req_payload.cmd;
               key_in = req_payload.key;
               case (req_payload.cmd)
                  hfmi_pkg::CMD_INSERT: begin
                     if (count_ff >= PW'(MAX_ENTRIES)) begin
                        overflow_in = 1'b1;
                     end else begin
                        key_we   = 1'b1;
                        count_in = count_ff + PW'(1);
                        pos_in   = count_ff + PW'(1);
                        state_in = ST_HASH;
                     end
                  end
                  hfmi_pkg::CMD_LOOKUP: begin
                     state_in = ST_HASH;
                  end
                  hfmi_pkg::CMD_CLEAR: begin
                     count_in = '0;
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            slot_we = 1'b1;
            slot_wa = clr_ff;
            slot_wd = '0;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_HASH: begin
            state_in = ST_HOME;
         end
         ST_HOME: begin
            if (!home_ok) begin
               // direct key out of range
               if (cmd_ff == hfmi_pkg::CMD_LOOKUP) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = make_rsp('0, cfg_ff.nomatch_value, overflow_ff);
               end
               state_in = ST_IDLE;
            end else begin
               slot_idx_in = home_slot;
               probe_in    = '0;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (cfg_ff.mode || (slot_rdata == '0)) begin
               if (cmd_ff == hfmi_pkg::CMD_LOOKUP) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = make_rsp(slot_rdata, cfg_ff.nomatch_value, overflow_ff);
               end else if (slot_rdata == '0) begin
                  slot_we = 1'b1;
               end
               state_in = ST_IDLE;
            end else begin
               state_in = ST_KEY;
            end
         end
         ST_KEY: begin
            if (key_rdata == key_ff) begin
               if (cmd_ff == hfmi_pkg::CMD_LOOKUP) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = make_rsp(slot_rdata, cfg_ff.nomatch_value, overflow_ff);
               end
               state_in = ST_IDLE;
            end else if (probe_ff == slot_mask) begin
               // walked every slot in use without a match or a hole
               if (cmd_ff == hfmi_pkg::CMD_LOOKUP) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = make_rsp('0, cfg_ff.nomatch_value, overflow_ff);
               end else begin
                  overflow_in = 1'b1;
               end
               state_in = ST_IDLE;
            end else begin
               probe_in    = probe_ff + AW'(1);
               slot_idx_in = (slot_idx_ff + AW'(1)) & slot_mask;
               state_in    = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cfg_ff       <= hfmi_pkg::CFG_RESET;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      pos_ff      <= pos_in;
      slot_idx_ff <= slot_idx_in;
      probe_ff    <= probe_in;
      rsp_ff      <= rsp_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

endmodule

`default_nettype wire

/* hw/rtl/hfmi_chk.sv */
// hfmi_chk: port-level assertions for the first-match index block, bound to the top
// depends on hfmi_pkg and hash_first_match_index
`default_nettype none

module hfmi_chk #(
   parameter int MAX_ENTRIES = hfmi_pkg::DEF_MAX_ENTRIES
) (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           start,
   input wire logic                           busy,
   input wire hfmi_pkg::req_type              req_payload,
   input wire logic                           rsp_valid,
   input wire hfmi_pkg::rsp_type              rsp_payload
);

   // a lookup or clear transaction always occupies the block
   a_cmd_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_payload.cmd == hfmi_pkg::CMD_LOOKUP ||
                          req_payload.cmd == hfmi_pkg::CMD_CLEAR)) |=> busy)
      else $error("lookup or clear accepted without going busy");

   // results only close a busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a preceding busy period");

   // one result per lookup, never two in a row
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result strobes");

   // a found position is a valid 1-based table position
   a_found_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.found) |->
         (rsp_payload.match_value > 0 && rsp_payload.match_value <= MAX_ENTRIES))
      else $error("found position out of range");

endmodule

bind hash_first_match_index hfmi_chk #(.MAX_ENTRIES(MAX_ENTRIES)) u_hfmi_chk (.*);

`default_nettype wire
